@@ src/base64_stream_encoder_assert.svh @@
// Assertion macros for the base64 stream encoder checker.
// Needs clk and rst_n in the scope of each use.
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// Same-cycle implication, off during reset
`define B64E_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define B64E_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/b64e_pkg.sv @@
// Shared types, constants and the character map of the base64 stream encoder.
// No dependencies.
`timescale 1ns / 1ps

package b64e_pkg;

  localparam int BYTE_W     = 8;
  localparam int SYM_W      = 6;
  localparam int HELD_W     = 4;
  localparam int GRP_CHARS  = 4;
  localparam int POS_W      = $clog2(GRP_CHARS);
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [BYTE_W-1:0] PAD_CHAR = 8'h3D;

  // first character sits at index 0
  localparam logic [0:63][BYTE_W-1:0] ALPHABET =
    "Ag9jCXabcJKLV2345WmnopuvwxYZklMhi78NOPrstTUByz0defDEFGHI16+/QRSq";

  typedef enum logic [2:0] {
    PH_0 = 3'b001,
    PH_1 = 3'b010,
    PH_2 = 3'b100
  } phase_t;

  // one output character before mapping: a 6-bit symbol or a pad
  typedef struct packed {
    logic             pad;
    logic [SYM_W-1:0] idx;
  } code_t;

  // everything one byte produces, handed from front to back
  typedef struct packed {
    code_t [GRP_CHARS-1:0] code;
    logic  [POS_W-1:0]     cnt_m1;
    logic                  last;
  } grp_t;

  function automatic logic [BYTE_W-1:0] code_char(input code_t c);
    logic [BYTE_W-1:0] ch;
    if (c.pad) begin
      ch = PAD_CHAR;
    end else begin
      ch = ALPHABET[c.idx];
    end
    return ch;
  endfunction

endpackage

@@ src/b64e_if.sv @@
// Valid/ready channel interfaces of the base64 stream encoder.
// Depends on b64e_pkg.
`timescale 1ns / 1ps

interface b64e_in_if;
  import b64e_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last;
  modport source (output valid, data_byte, last, input ready);
  modport sink   (input valid, data_byte, last, output ready);
endinterface

interface b64e_out_if;
  import b64e_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_char;
  logic              out_last;
  modport source (output valid, out_char, out_last, input ready);
  modport sink   (input valid, out_char, out_last, output ready);
endinterface

@@ src/b64e_front.sv @@
// Front end: takes bytes, tracks the group phase and leftover bits,
// and splits each byte into its symbol codes. Depends on b64e_pkg, b64e_if.
`timescale 1ns / 1ps

module b64e_front (
  input  logic            clk,
  input  logic            rst_n,
  b64e_in_if.sink         in_s,
  output logic            push_valid,
  output b64e_pkg::grp_t  push_data,
  input  logic            push_ready
);
  import b64e_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  logic [BYTE_W-1:0] b;
  logic              acc;
  grp_t              grp;

  assign b          = in_s.data_byte;
  assign in_s.ready = push_ready;
  assign push_valid = in_s.valid;
  assign acc        = in_s.valid && push_ready;
  assign push_data  = grp;

  always_comb begin
    grp       = '0;
    grp.last  = in_s.last;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    unique case (phase_r)
      PH_1: begin
        grp.code[0].idx = {held_r[1:0], b[7:4]};
        if (in_s.last) begin
          grp.code[1].idx = {b[3:0], 2'b00};
          grp.code[2].pad = 1'b1;
          grp.cnt_m1      = POS_W'(2);
        end
        held_nxt  = b[3:0];
        phase_nxt = PH_2;
      end
      PH_2: begin
        grp.code[0].idx = {held_r[3:0], b[7:6]};
        grp.code[1].idx = b[5:0];
        grp.cnt_m1      = POS_W'(1);
        held_nxt        = '0;
        phase_nxt       = PH_0;
      end
      default: begin
        grp.code[0].idx = b[7:2];
        if (in_s.last) begin
          grp.code[1].idx = {b[1:0], 4'b0000};
          grp.code[2].pad = 1'b1;
          grp.code[3].pad = 1'b1;
          grp.cnt_m1      = POS_W'(3);
        end
        held_nxt  = {2'b00, b[1:0]};
        phase_nxt = PH_1;
      end
    endcase
    // final byte closes the group
    if (in_s.last) begin
      held_nxt  = '0;
      phase_nxt = PH_0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_0;
      held_r  <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

@@ src/b64e_fifo.sv @@
// Short queue of symbol groups between front and back ends.
// Depends on b64e_pkg.
`timescale 1ns / 1ps

module b64e_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  b64e_pkg::grp_t  push_data,
  output logic            push_ready,
  output logic            pop_valid,
  output b64e_pkg::grp_t  pop_data,
  input  logic            pop_ready
);
  import b64e_pkg::*;

  grp_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

@@ src/b64e_back.sv @@
// Back end: unless stalled, walks one symbol group a character per cycle
// into the output register via the alphabet. Depends on b64e_pkg, b64e_if.
`timescale 1ns / 1ps

module b64e_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            grp_valid,
  input  b64e_pkg::grp_t  grp_data,
  output logic            grp_ready,
  b64e_out_if.source      out_s
);
  import b64e_pkg::*;

  grp_t              cur_r;
  logic              have_r;
  logic [POS_W-1:0]  pos_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_char_r;
  logic              out_last_r;
  logic              emit, at_end, take;

  assign emit      = have_r && (!out_valid_r || out_s.ready);
  assign at_end    = (pos_r == cur_r.cnt_m1);
  // next group loads in the cycle the current one hands out its final char
  assign grp_ready = !have_r || (emit && at_end);
  assign take      = grp_valid && grp_ready;

  assign out_s.valid    = out_valid_r;
  assign out_s.out_char = out_char_r;
  assign out_s.out_last = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r      <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_s.ready) begin
        out_valid_r <= 1'b0;
      end
      if (take) begin
        have_r <= 1'b1;
        pos_r  <= '0;
      end else if (emit && at_end) begin
        have_r <= 1'b0;
      end else if (emit) begin
        pos_r <= pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_r <= grp_data;
    end
    if (emit) begin
      out_char_r <= code_char(cur_r.code[pos_r]);
      out_last_r <= cur_r.last && at_end;
    end
  end

endmodule

@@ src/base64_stream_encoder.sv @@
// Top level of the base64 stream encoder: front end, group queue, back end.
// Depends on b64e_pkg, b64e_if, b64e_front, b64e_fifo, b64e_back.
//
//   channel | dir | payload              | handshake
//   in_s    | in  | data_byte[7:0], last | valid/ready
//   out_s   | out | out_char[7:0], out_last | valid/ready
//
// A byte is taken every cycle while the two-entry group queue has room.
// The back end hands out one character a cycle unless the output stalls:
// a normal byte yields one or two characters, a final byte up to four; the
// back end sets the sustained rate.
// Reset is synchronous, active low; it clears phase, queue and output valid.
// A stalled output holds its character; the queue absorbs the stall first.
`timescale 1ns / 1ps

module base64_stream_encoder (
  input  logic        clk,
  input  logic        rst_n,
  b64e_in_if.sink     in_s,
  b64e_out_if.source  out_s
);
  import b64e_pkg::*;

  logic f_valid, f_ready, b_valid, b_ready;
  grp_t f_data, b_data;

  b64e_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_s       (in_s),
    .push_valid (f_valid),
    .push_data  (f_data),
    .push_ready (f_ready)
  );

  b64e_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_data  (f_data),
    .push_ready (f_ready),
    .pop_valid  (b_valid),
    .pop_data   (b_data),
    .pop_ready  (b_ready)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_valid (b_valid),
    .grp_data  (b_data),
    .grp_ready (b_ready),
    .out_s     (out_s)
  );

endmodule

@@ src/b64e_chk.sv @@
// Port-level checker for the base64 stream encoder, bound to the top level.
// Depends on b64e_pkg and base64_stream_encoder_assert.svh.
`timescale 1ns / 1ps
`include "base64_stream_encoder_assert.svh"

module b64e_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last
);
  import b64e_pkg::*;

  logic seen_in_r;
  logic pad_run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_in_r <= 1'b0;
      pad_run_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        seen_in_r <= 1'b1;
      end
      if (out_valid && out_ready) begin
        pad_run_r <= (out_char == PAD_CHAR) && !out_last;
      end
    end
  end

  `B64E_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(out_last), "output changed while stalled")
  `B64E_ASSERT_IMP(a_no_phantom, out_valid, seen_in_r, "character before any byte was taken")
  `B64E_ASSERT_IMP(a_pad_run, out_valid && pad_run_r, out_char == PAD_CHAR, "padding broken before message end")

endmodule

bind base64_stream_encoder b64e_chk u_b64e_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_s.valid),
  .in_ready  (in_s.ready),
  .out_valid (out_s.valid),
  .out_ready (out_s.ready),
  .out_char  (out_s.out_char),
  .out_last  (out_s.out_last)
);
